/* sv/gpc_pkg.sv */
// Shared constants, types and unit interface structs for the glyph pixel compositor.
package gpc_pkg;

  // Framebuffer geometry.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 64;
  localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(PIX_DEPTH);

  // Coordinates and clipping arithmetic.
  localparam int COORD_W = 12;
  localparam int CMP_W   = COORD_W + 1;
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int EW_W    = $clog2(MAX_WIDTH + 1);
  localparam int PROD_W  = YW + EW_W;

  // Configuration port.
  localparam int WCFG_W     = 9;
  localparam int HCFG_W     = 7;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 1'b1;
  localparam logic [WCFG_W-1:0]    DEST_WIDTH_RST  = 9'd256;
  localparam logic [HCFG_W-1:0]    DEST_HEIGHT_RST = 7'd64;

  // Operation codes.
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_BLEND   = 2'd0;
  localparam logic [OP_W-1:0] OP_RESOLVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Pixel channels.
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 4 * CHAN_W;
  localparam logic [CHAN_W-1:0] FULL = 8'hFF;
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  // Restoring division: one quotient bit per step.
  localparam int DIV_STEPS = CHAN_W;
  localparam int BIT_W     = $clog2(DIV_STEPS);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(DIV_STEPS - 1);

  typedef logic [CHAN_W-1:0]      chan_t;
  typedef logic [3:0][CHAN_W-1:0] pixel_t;
  typedef logic [2:0][CHAN_W-1:0] colour_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  typedef enum logic {
    AR_MUL,
    AR_DIV
  } arith_mode_t;

  // Request to the shared unit: (m0*m1 + m2*m3)/255, or one division step.
  typedef struct packed {
    arith_mode_t mode;
    chan_t       m0;
    chan_t       m1;
    chan_t       m2;
    chan_t       m3;
    chan_t       rem;
    logic        bit_in;
    chan_t       divisor;
  } arith_req_t;

  typedef struct packed {
    chan_t quot;
    chan_t rem;
    logic  qbit;
  } arith_rsp_t;

endpackage

/* sv/gpc_frame_ram.sv */
// Single-port-write, single-port-read framebuffer memory with registered read data.
module gpc_frame_ram (
  input  logic            clk,
  input  logic            we,
  input  gpc_pkg::addr_t  waddr,
  input  gpc_pkg::pixel_t wdata,
  input  gpc_pkg::addr_t  raddr,
  output gpc_pkg::pixel_t rdata
);
  import gpc_pkg::*;

  pixel_t mem [PIX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/gpc_arith.sv */
// Shared arithmetic unit: sum of two 8x8 products divided by 255, or one restoring division step.
module gpc_arith (
  input  gpc_pkg::arith_req_t req,
  output gpc_pkg::arith_rsp_t rsp
);
  import gpc_pkg::*;

  logic [16:0]       prod_sum;
  logic [16:0]       quot_wide;
  logic [CHAN_W:0]   trial;
  logic              fits;

  // Exact division by 255 for sums below 65536: (v + (v >> 8) + 1) >> 8.
  assign prod_sum  = 17'(req.m0 * req.m1) + 17'(req.m2 * req.m3);
  assign quot_wide = (prod_sum + {8'h00, prod_sum[16:8]} + 17'd1) >> 8;

  assign trial = {req.rem, req.bit_in};
  assign fits  = trial >= {1'b0, req.divisor};

  always_comb begin
    rsp = '0;
    unique case (req.mode)
      AR_MUL: begin
        rsp.quot = quot_wide[CHAN_W-1:0];
      end
      AR_DIV: begin
        rsp.qbit = fits;
        rsp.rem  = fits ? CHAN_W'(trial - {1'b0, req.divisor}) : trial[CHAN_W-1:0];
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

/* sv/glyph_pixel_compositor.sv */
// Top level of the glyph pixel compositor: sequencer, clipping, address and result register.
//
// Input channel (in_valid / in_stall): one transfer carries an operation, a signed
// position and, for a blend, a glyph source pixel and a tint colour. Output channel
// (out_valid / out_stall): one transfer per input item, carrying the resulting pixel and
// the clipped flag. The configuration port (cfg_write, cfg_index, cfg_data) sets the
// clipping width and height and should only be written while the block is idle.
// Items are handled one at a time by a small sequencer around a single shared unit that
// multiplies and divides by 255, or performs one restoring division step per cycle.
// A clipped, unused or clear item takes the address step, then the output register; a
// blend takes address, read, one unit pass for coverage, three for tinting, three for
// mixing, one for alpha, then the output register; at zero coverage a blend stops after
// its first unit pass; a resolve of a transparent pixel stops after the read; a resolve
// takes a setup step and up to eight division steps per colour channel. The next item
// can be taken in the cycle after the result is loaded into the output register, so a
// result waiting under a stalled receiver only holds the block once the next item is
// finished. After reset the block sweeps the whole framebuffer to zero, one pixel per
// cycle, and keeps in_stall high meanwhile; configuration writes are taken as ever.
// When out_stall is high the finished result simply waits in its register.
module glyph_pixel_compositor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gpc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          operation,
  input  logic signed [gpc_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [gpc_pkg::COORD_W-1:0]  pos_y,
  input  logic [7:0]                          src_red,
  input  logic [7:0]                          src_green,
  input  logic [7:0]                          src_blue,
  input  logic [7:0]                          src_alpha,
  input  logic [7:0]                          tint_red,
  input  logic [7:0]                          tint_green,
  input  logic [7:0]                          tint_blue,
  input  logic [7:0]                          tint_alpha,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          pix_red,
  output logic [7:0]                          pix_green,
  output logic [7:0]                          pix_blue,
  output logic [7:0]                          pix_alpha,
  output logic                                clipped
);
  import gpc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_LOAD,
    ST_COV,
    ST_TINT,
    ST_MIX,
    ST_ALPHA,
    ST_RSET,
    ST_RDIV,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [WCFG_W-1:0] dest_width;
  logic [HCFG_W-1:0] dest_height;

  // Latched input item.
  logic [OP_W-1:0]           op_r;
  logic signed [COORD_W-1:0] pos_x_r;
  logic signed [COORD_W-1:0] pos_y_r;
  colour_t                   src_c;
  colour_t                   tint_c;
  chan_t                     src_a;
  chan_t                     tint_a;

  // Working registers.
  pixel_t          pix;
  colour_t         tinted;
  chan_t           cov;
  addr_t           addr_r;
  addr_t           clr_cnt;
  logic            clip_r;
  logic [1:0]      ch;
  logic [BIT_W-1:0] bit_cnt;
  chan_t           div_rem;
  chan_t           div_low;
  chan_t           quo;

  // Clipping and address.
  logic [CMP_W-1:0]  w_eff;
  logic [CMP_W-1:0]  h_eff;
  logic              outside;
  logic              op_unused;
  logic [PROD_W-1:0] row_base;
  addr_t             idx;

  // Resolve setup.
  logic [15:0] res_num;
  logic        res_sat;

  // Alpha accumulation.
  logic [CHAN_W:0] na_sum;
  chan_t           na;

  // Memory and shared unit.
  logic       ram_we;
  addr_t      ram_waddr;
  pixel_t     ram_wdata;
  pixel_t     ram_rdata;
  arith_req_t ar_req;
  arith_rsp_t ar_rsp;

  assign in_stall = (state != ST_IDLE);

  // The effective size is the register value capped at the buffer's real size.
  assign w_eff = (CMP_W'(dest_width) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                          : CMP_W'(dest_width);
  assign h_eff = (CMP_W'(dest_height) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT)
                                                            : CMP_W'(dest_height);

  assign outside = pos_x_r[COORD_W-1] || pos_y_r[COORD_W-1] ||
                   ({1'b0, pos_x_r} >= w_eff) || ({1'b0, pos_y_r} >= h_eff);
  assign op_unused = (op_r != OP_BLEND) && (op_r != OP_RESOLVE) && (op_r != OP_CLEAR);

  // Inside the buffer, y * width + x always lies below the store's depth.
  assign row_base = PROD_W'(pos_y_r[YW-1:0]) * PROD_W'(w_eff[EW_W-1:0]);
  assign idx      = ADDR_W'(row_base) + ADDR_W'(pos_x_r[XW-1:0]);

  // Straight-alpha numerator c*255 + a/2; the quotient saturates when it reaches 256.
  assign res_num = {pix[ch], 8'h00} - {8'h00, pix[ch]} + {9'h000, pix[CH_ALPHA][7:1]};
  assign res_sat = res_num[15:8] >= pix[CH_ALPHA];

  assign na_sum = {1'b0, pix[CH_ALPHA]} + {1'b0, ar_rsp.quot};
  assign na     = na_sum[CHAN_W] ? FULL : na_sum[CHAN_W-1:0];

  gpc_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  gpc_arith u_arith (
    .req (ar_req),
    .rsp (ar_rsp)
  );

  // Operands for the shared unit in each step.
  always_comb begin
    ar_req = '0;
    unique case (state)
      ST_COV: begin
        ar_req.mode = AR_MUL;
        ar_req.m0   = src_a;
        ar_req.m1   = tint_a;
      end
      ST_TINT: begin
        ar_req.mode = AR_MUL;
        ar_req.m0   = src_c[ch];
        ar_req.m1   = tint_c[ch];
      end
      ST_MIX: begin
        ar_req.mode = AR_MUL;
        ar_req.m0   = pix[ch];
        ar_req.m1   = ~cov;
        ar_req.m2   = tinted[ch];
        ar_req.m3   = cov;
      end
      ST_ALPHA: begin
        ar_req.mode = AR_MUL;
        ar_req.m0   = ~pix[CH_ALPHA];
        ar_req.m1   = cov;
      end
      ST_RDIV: begin
        ar_req.mode    = AR_DIV;
        ar_req.rem     = div_rem;
        ar_req.bit_in  = div_low[CHAN_W-1];
        ar_req.divisor = pix[CH_ALPHA];
      end
      default: begin
        ar_req = '0;
      end
    endcase
  end

  // Framebuffer writes: the clearing sweep, a clear item, and the end of a blend.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      ST_ADDR: begin
        ram_we    = !op_unused && !outside && (op_r == OP_CLEAR);
        ram_waddr = idx;
      end
      ST_ALPHA: begin
        ram_we    = 1'b1;
        ram_wdata = {na, pix[CH_BLUE], pix[1], pix[CH_RED]};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
      dest_width  <= DEST_WIDTH_RST;
      dest_height <= DEST_HEIGHT_RST;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DEST_WIDTH:  dest_width  <= cfg_data[WCFG_W-1:0];
          REG_DEST_HEIGHT: dest_height <= cfg_data[HCFG_W-1:0];
          default: begin
          end
        endcase
      end

      // In the result step the output register is reloaded below instead.
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + addr_t'(1);
          if (clr_cnt == addr_t'(PIX_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_r    <= operation;
            pos_x_r <= pos_x;
            pos_y_r <= pos_y;
            src_c   <= {src_blue, src_green, src_red};
            tint_c  <= {tint_blue, tint_green, tint_red};
            src_a   <= src_alpha;
            tint_a  <= tint_alpha;
            state   <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          addr_r <= idx;
          priority if (op_unused) begin
            pix    <= '0;
            clip_r <= 1'b0;
            state  <= ST_DONE;
          end else if (outside) begin
            pix    <= '0;
            clip_r <= 1'b1;
            state  <= ST_DONE;
          end else if (op_r == OP_CLEAR) begin
            pix    <= '0;
            clip_r <= 1'b0;
            state  <= ST_DONE;
          end else begin
            clip_r <= 1'b0;
            state  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          pix <= ram_rdata;
          ch  <= CH_RED;
          priority if (op_r == OP_BLEND) begin
            state <= ST_COV;
          end else if (ram_rdata[CH_ALPHA] == '0) begin
            state <= ST_DONE;
          end else begin
            state <= ST_RSET;
          end
        end
        ST_COV: begin
          cov   <= ar_rsp.quot;
          state <= (ar_rsp.quot == '0) ? ST_DONE : ST_TINT;
        end
        ST_TINT: begin
          tinted[ch] <= ar_rsp.quot;
          if (ch == CH_BLUE) begin
            ch    <= CH_RED;
            state <= ST_MIX;
          end else begin
            ch <= ch + 2'd1;
          end
        end
        ST_MIX: begin
          pix[ch] <= ar_rsp.quot;
          if (ch == CH_BLUE) begin
            state <= ST_ALPHA;
          end else begin
            ch <= ch + 2'd1;
          end
        end
        ST_ALPHA: begin
          pix[CH_ALPHA] <= na;
          state         <= ST_DONE;
        end
        ST_RSET: begin
          if (res_sat) begin
            pix[ch] <= FULL;
            if (ch == CH_BLUE) begin
              state <= ST_DONE;
            end else begin
              ch <= ch + 2'd1;
            end
          end else begin
            div_rem <= res_num[15:8];
            div_low <= res_num[7:0];
            bit_cnt <= '0;
            state   <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          div_rem <= ar_rsp.rem;
          div_low <= {div_low[CHAN_W-2:0], 1'b0};
          quo     <= {quo[CHAN_W-2:0], ar_rsp.qbit};
          bit_cnt <= bit_cnt + BIT_W'(1);
          if (bit_cnt == BIT_LAST) begin
            pix[ch] <= {quo[CHAN_W-2:0], ar_rsp.qbit};
            if (ch == CH_BLUE) begin
              state <= ST_DONE;
            end else begin
              ch    <= ch + 2'd1;
              state <= ST_RSET;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            pix_red   <= pix[CH_RED];
            pix_green <= pix[1];
            pix_blue  <= pix[CH_BLUE];
            pix_alpha <= pix[CH_ALPHA];
            clipped   <= clip_r;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The framebuffer is only written by the sweep, a clear item or the end of a blend.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_ADDR || state == ST_ALPHA))
    else $error("framebuffer written outside a writing step");

  // An accepted item always starts with the address step.
  a_accept_to_addr: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_ADDR))
    else $error("accepted item did not enter the address step");

  // A clipped result never carries pixel data.
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (pix_red == '0 && pix_green == '0 && pix_blue == '0 && pix_alpha == '0))
    else $error("clipped result carries pixel data");

  // The division remainder stays below the stored alpha.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDIV) |-> (div_rem < pix[CH_ALPHA]))
    else $error("division remainder not below divisor");

  // Mixing only runs with a non-zero coverage.
  a_mix_cov: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIX || state == ST_ALPHA) |-> (cov != '0))
    else $error("blend mixing with zero coverage");

endmodule
